>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, quiet while reset is high
`define FPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge, reset included
`define FPT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/fpt_pkg.sv
`default_nettype none

package fpt_pkg;

  // Fixed field widths
  localparam int TIME_BITS  = 48;
  localparam int ID_BITS    = 32;
  localparam int LIMIT_BITS = 9;

  // Default table sizes
  localparam int INFLIGHT_DEPTH_DEF = 64;
  localparam int SAMPLE_DEPTH_DEF   = 256;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 9'd256;

  // Register index on the configuration port (byte address 4*index)
  localparam logic REG_SAMPLE_LIMIT = 1'b0;

  // Event kinds
  localparam logic [2:0] MODE_TAKEN  = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_SENT   = 3'd2;
  localparam logic [2:0] MODE_ACK    = 3'd3;
  localparam logic [2:0] MODE_REPORT = 3'd4;

  // Report metric codes
  localparam logic [3:0] METRIC_FRAMES      = 4'd0;
  localparam logic [3:0] METRIC_NO_CAPTURE  = 4'd1;
  localparam logic [3:0] METRIC_WAIT_P50    = 4'd2;
  localparam logic [3:0] METRIC_READ_P50    = 4'd4;
  localparam logic [3:0] METRIC_ENC_P50     = 4'd6;
  localparam logic [3:0] METRIC_CLIENT_P50  = 4'd8;
  localparam logic [3:0] METRIC_SERVER_P50  = 4'd10;
  localparam logic [3:0] METRIC_TOTAL_P50   = 4'd13;
  localparam logic [3:0] METRIC_LAST        = 4'd15;

  // Duration figures, in sample word order
  localparam logic [2:0] FIG_WAITING  = 3'd0;
  localparam logic [2:0] FIG_READING  = 3'd1;
  localparam logic [2:0] FIG_ENCODING = 3'd2;
  localparam logic [2:0] FIG_CLIENT   = 3'd3;
  localparam logic [2:0] FIG_SERVER   = 3'd4;
  localparam logic [2:0] FIG_TOTAL    = 3'd5;

  // p95 rank = floor((95*(n-1)+50)/100) = floor(((95*(n-1)+50)>>2)/25);
  // the /25 is a multiply by ceil(2^22/25), exact for operands below 2^17
  localparam int P95_MUL      = 95;
  localparam int P95_BIAS     = 50;
  localparam int RECIP_25     = 167773;
  localparam int RECIP_BITS   = 18;
  localparam int RECIP_SHIFT  = 22;

  typedef struct packed {
    logic [2:0]           mode;
    logic [TIME_BITS-1:0] time_now;
    logic                 capture_valid;
    logic [TIME_BITS-1:0] capture_time;
    logic [ID_BITS-1:0]   frame_tag;
  } in_item_t;

  typedef struct packed {
    logic [3:0]           metric;
    logic [TIME_BITS-1:0] value;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] waiting;
    logic [TIME_BITS-1:0] reading;
    logic [TIME_BITS-1:0] encoding;
    logic [TIME_BITS-1:0] sent;
  } flight_entry_t;

  // Waiting sits in the low bits so figure f is bits [f*TIME_BITS +: TIME_BITS]
  typedef struct packed {
    logic [TIME_BITS-1:0] total;
    logic [TIME_BITS-1:0] server;
    logic [TIME_BITS-1:0] client;
    logic [TIME_BITS-1:0] encoding;
    logic [TIME_BITS-1:0] reading;
    logic [TIME_BITS-1:0] waiting;
  } sample_entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SENT_ADJ,
    ST_SENT_WR,
    ST_ACK_RD,
    ST_ACK_CMP,
    ST_ACK_SUM1,
    ST_ACK_SUM2,
    ST_ACK_SUM3,
    ST_ACK_WR,
    ST_REP_CNT0,
    ST_REP_CNT1,
    ST_REP_METRIC,
    ST_CAND_RD,
    ST_CAND_LD,
    ST_SWEEP,
    ST_DECIDE,
    ST_EMIT50,
    ST_EMIT95,
    ST_EMITMAX
  } state_t;

  // Difference clamped at zero
  function automatic logic [TIME_BITS-1:0] diff_clamp(
    input logic [TIME_BITS-1:0] later,
    input logic [TIME_BITS-1:0] earlier
  );
    return (later >= earlier) ? (later - earlier) : '0;
  endfunction

  // Sum saturating at all ones
  function automatic logic [TIME_BITS-1:0] add_sat(
    input logic [TIME_BITS-1:0] a,
    input logic [TIME_BITS-1:0] b
  );
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  // First metric code of a figure
  function automatic logic [3:0] metric_base(input logic [2:0] fig);
    logic [3:0] m;
    case (fig)
      FIG_WAITING:  m = METRIC_WAIT_P50;
      FIG_READING:  m = METRIC_READ_P50;
      FIG_ENCODING: m = METRIC_ENC_P50;
      FIG_CLIENT:   m = METRIC_CLIENT_P50;
      FIG_SERVER:   m = METRIC_SERVER_P50;
      default:      m = METRIC_TOTAL_P50;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fpt_ram.sv
`default_nettype none

module fpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word; read one word with registered output data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/frame_latency_percentile_tracker_core.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// in        to block   in_valid/in_stall  in_item  (fpt_pkg::in_item_t)
// out       from block out_valid/out_stall out_item (fpt_pkg::out_item_t)
// config    to block   APB write/read     sample_limit at byte address 0
//
// Taken, read and unknown items end on acceptance, as does sent with no frame
// pending. Else sent frees room in the in-flight ring, then writes the entry.
// Acknowledged reads and compares in-flight entries in turn through the one RAM
// read port, then builds and stores the sample. Report emits the two counts, then
// ranks each of six figures, comparing every sample against every other through
// the sample RAM read port, and emits median, p95 and, for server and total, max.
// Synchronous reset returns to idle with empty tables; no clearing pass is needed.
// A stalled result holds the output register and the sequencer waits on it.

module frame_latency_percentile_tracker_core #(
  parameter int INFLIGHT_DEPTH = fpt_pkg::INFLIGHT_DEPTH_DEF,
  parameter int SAMPLE_DEPTH   = fpt_pkg::SAMPLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fpt_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fpt_pkg::out_item_t      out_item,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int TB  = fpt_pkg::TIME_BITS;
  localparam int FAW = (INFLIGHT_DEPTH > 1) ? $clog2(INFLIGHT_DEPTH) : 1;
  localparam int FCW = $clog2(INFLIGHT_DEPTH + 1);
  localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int SCW = $clog2(SAMPLE_DEPTH + 1);
  localparam int XW  = SCW + 8;
  localparam int PW  = XW - 2 + fpt_pkg::RECIP_BITS;
  localparam int FW  = $bits(fpt_pkg::flight_entry_t);
  localparam int SW  = $bits(fpt_pkg::sample_entry_t);

  // Pointer steps with wrap for any depth
  function automatic logic [FAW-1:0] f_inc(input logic [FAW-1:0] p);
    return (p == FAW'(INFLIGHT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [FAW-1:0] f_add(input logic [FAW-1:0] h,
                                           input logic [FCW-1:0] c);
    logic [FCW:0] s;
    s = (FCW+1)'(h) + (FCW+1)'(c);
    if (s >= (FCW+1)'(INFLIGHT_DEPTH)) begin
      s = s - (FCW+1)'(INFLIGHT_DEPTH);
    end
    return s[FAW-1:0];
  endfunction

  function automatic logic [SAW-1:0] s_inc(input logic [SAW-1:0] p);
    return (p == SAW'(SAMPLE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SAW-1:0] s_add(input logic [SAW-1:0] h,
                                           input logic [SCW-1:0] c);
    logic [SCW:0] s;
    s = (SCW+1)'(h) + (SCW+1)'(c);
    if (s >= (SCW+1)'(SAMPLE_DEPTH)) begin
      s = s - (SCW+1)'(SAMPLE_DEPTH);
    end
    return s[SAW-1:0];
  endfunction

  // Select one duration figure from a sample word
  function automatic logic [TB-1:0] pick(input fpt_pkg::sample_entry_t e,
                                         input logic [2:0] fig);
    logic [TB-1:0] v;
    case (fig)
      fpt_pkg::FIG_WAITING:  v = e.waiting;
      fpt_pkg::FIG_READING:  v = e.reading;
      fpt_pkg::FIG_ENCODING: v = e.encoding;
      fpt_pkg::FIG_CLIENT:   v = e.client;
      fpt_pkg::FIG_SERVER:   v = e.server;
      default:               v = e.total;
    endcase
    return v;
  endfunction

  fpt_pkg::state_t state_q, state_next;

  logic [fpt_pkg::LIMIT_BITS-1:0] sample_limit_q;

  logic          pend_valid_q;
  logic [TB-1:0] pend_taken_q;
  logic          pend_cap_valid_q;
  logic [TB-1:0] pend_captured_q;
  logic          pend_has_read_q;
  logic [TB-1:0] pend_read_q;

  logic [FAW-1:0] flight_head_q;
  logic [FCW-1:0] flight_count_q;
  logic [SAW-1:0] sample_head_q;
  logic [SCW-1:0] sample_count_q;
  logic [31:0]    no_cap_q;

  logic [TB-1:0]               now_q;
  logic [fpt_pkg::ID_BITS-1:0] id_q;
  logic [FAW-1:0]              ptr_q;
  logic [FCW-1:0]              k_q;
  fpt_pkg::sample_entry_t      smp_q;

  logic [2:0]     fig_q;
  logic [SCW-1:0] i_cnt_q, j_cnt_q, less_q, leq_q, i95_q;
  logic [SAW-1:0] ptr_i_q, ptr_j_q;
  logic [TB-1:0]  cand_q, res50_q, res95_q, resmax_q;
  logic           rd_pend_q;
  logic [XW-1:0]  rank_x_q;

  logic               out_valid_q;
  fpt_pkg::out_item_t out_item_q;

  // RAM ports
  fpt_pkg::flight_entry_t fram_wdata, fram_rdata;
  logic                   fram_we;
  logic [FAW-1:0]         fram_waddr;
  fpt_pkg::sample_entry_t sram_rdata;
  logic                   sram_we;
  logic [SAW-1:0]         sram_waddr, sram_raddr;

  logic               emit_req, out_free, cfg_wr;
  fpt_pkg::out_item_t emit_item;
  logic [SCW-1:0]     lim, i50, rmax;
  logic [TB-1:0]      rd_time, val_j;
  logic [PW-1:0]      recip_prod;
  logic [3:0]         base;

  fpt_ram #(.WIDTH(FW), .DEPTH(INFLIGHT_DEPTH)) u_flight_ram (
    .clk   (clk),
    .we    (fram_we),
    .waddr (fram_waddr),
    .wdata (fram_wdata),
    .raddr (ptr_q),
    .rdata (fram_rdata)
  );

  fpt_ram #(.WIDTH(SW), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (smp_q),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == fpt_pkg::REG_SAMPLE_LIMIT);
  assign prdata = (paddr[2] == fpt_pkg::REG_SAMPLE_LIMIT) ? 32'(sample_limit_q) : '0;

  // Effective sample limit, ranks and helpers
  always_comb begin
    if (sample_limit_q == '0) begin
      lim = SCW'(1);
    end else if (32'(sample_limit_q) > SAMPLE_DEPTH) begin
      lim = SCW'(SAMPLE_DEPTH);
    end else begin
      lim = SCW'(sample_limit_q);
    end
    i50        = sample_count_q >> 1;
    rmax       = sample_count_q - 1'b1;
    rd_time    = pend_has_read_q ? pend_read_q : pend_taken_q;
    val_j      = pick(sram_rdata, fig_q);
    recip_prod = PW'(rank_x_q[XW-1:2]) * PW'(fpt_pkg::RECIP_25);
    base       = fpt_pkg::metric_base(fig_q);
    out_free   = !out_valid_q || !out_stall;
  end

  // Next state
  always_comb begin
    state_next = state_q;
    case (state_q)
      fpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_item.mode)
            fpt_pkg::MODE_SENT: begin
              if (pend_valid_q) state_next = fpt_pkg::ST_SENT_ADJ;
            end
            fpt_pkg::MODE_ACK: begin
              if (flight_count_q != '0) state_next = fpt_pkg::ST_ACK_RD;
            end
            fpt_pkg::MODE_REPORT: state_next = fpt_pkg::ST_REP_CNT0;
            default: state_next = fpt_pkg::ST_IDLE;
          endcase
        end
      end
      fpt_pkg::ST_SENT_ADJ: state_next = fpt_pkg::ST_SENT_WR;
      fpt_pkg::ST_SENT_WR:  state_next = fpt_pkg::ST_IDLE;
      fpt_pkg::ST_ACK_RD:   state_next = fpt_pkg::ST_ACK_CMP;
      fpt_pkg::ST_ACK_CMP: begin
        if (fram_rdata.id == id_q) begin
          state_next = fpt_pkg::ST_ACK_SUM1;
        end else if ((k_q + 1'b1) == flight_count_q) begin
          state_next = fpt_pkg::ST_IDLE;
        end else begin
          state_next = fpt_pkg::ST_ACK_RD;
        end
      end
      fpt_pkg::ST_ACK_SUM1: state_next = fpt_pkg::ST_ACK_SUM2;
      fpt_pkg::ST_ACK_SUM2: state_next = fpt_pkg::ST_ACK_SUM3;
      fpt_pkg::ST_ACK_SUM3: state_next = fpt_pkg::ST_ACK_WR;
      fpt_pkg::ST_ACK_WR:   state_next = fpt_pkg::ST_IDLE;
      fpt_pkg::ST_REP_CNT0: begin
        if (out_free) state_next = fpt_pkg::ST_REP_CNT1;
      end
      fpt_pkg::ST_REP_CNT1: begin
        if (out_free) state_next = fpt_pkg::ST_REP_METRIC;
      end
      fpt_pkg::ST_REP_METRIC: begin
        state_next = (sample_count_q == '0) ? fpt_pkg::ST_EMIT50 : fpt_pkg::ST_CAND_RD;
      end
      fpt_pkg::ST_CAND_RD: state_next = fpt_pkg::ST_CAND_LD;
      fpt_pkg::ST_CAND_LD: state_next = fpt_pkg::ST_SWEEP;
      fpt_pkg::ST_SWEEP: begin
        if (j_cnt_q == sample_count_q && !rd_pend_q) state_next = fpt_pkg::ST_DECIDE;
      end
      fpt_pkg::ST_DECIDE: begin
        state_next = ((i_cnt_q + 1'b1) == sample_count_q) ? fpt_pkg::ST_EMIT50
                                                          : fpt_pkg::ST_CAND_RD;
      end
      fpt_pkg::ST_EMIT50: begin
        if (out_free) state_next = fpt_pkg::ST_EMIT95;
      end
      fpt_pkg::ST_EMIT95: begin
        if (out_free) begin
          state_next = (fig_q >= fpt_pkg::FIG_SERVER) ? fpt_pkg::ST_EMITMAX
                                                      : fpt_pkg::ST_REP_METRIC;
        end
      end
      fpt_pkg::ST_EMITMAX: begin
        if (out_free) begin
          state_next = (fig_q == fpt_pkg::FIG_TOTAL) ? fpt_pkg::ST_IDLE
                                                     : fpt_pkg::ST_REP_METRIC;
        end
      end
      default: state_next = fpt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall   = (state_q != fpt_pkg::ST_IDLE);
    fram_we    = (state_q == fpt_pkg::ST_SENT_WR);
    fram_waddr = f_add(flight_head_q, flight_count_q);
    fram_wdata.id       = id_q;
    fram_wdata.waiting  = pend_cap_valid_q ? fpt_pkg::diff_clamp(pend_taken_q, pend_captured_q)
                                           : '0;
    fram_wdata.reading  = fpt_pkg::diff_clamp(rd_time, pend_taken_q);
    fram_wdata.encoding = fpt_pkg::diff_clamp(now_q, rd_time);
    fram_wdata.sent     = now_q;
    sram_we    = (state_q == fpt_pkg::ST_ACK_WR);
    sram_waddr = s_add(sample_head_q, sample_count_q);
    sram_raddr = (state_q == fpt_pkg::ST_CAND_RD) ? ptr_i_q : ptr_j_q;
    emit_req   = 1'b0;
    emit_item.metric = base;
    emit_item.value  = res50_q;
    case (state_q)
      fpt_pkg::ST_REP_CNT0: begin
        emit_req         = 1'b1;
        emit_item.metric = fpt_pkg::METRIC_FRAMES;
        emit_item.value  = TB'(sample_count_q);
      end
      fpt_pkg::ST_REP_CNT1: begin
        emit_req         = 1'b1;
        emit_item.metric = fpt_pkg::METRIC_NO_CAPTURE;
        emit_item.value  = TB'(no_cap_q);
      end
      fpt_pkg::ST_EMIT50: begin
        emit_req = 1'b1;
      end
      fpt_pkg::ST_EMIT95: begin
        emit_req         = 1'b1;
        emit_item.metric = base + 4'd1;
        emit_item.value  = res95_q;
      end
      fpt_pkg::ST_EMITMAX: begin
        emit_req         = 1'b1;
        emit_item.metric = base + 4'd2;
        emit_item.value  = resmax_q;
      end
      default: emit_req = 1'b0;
    endcase
    emit_item.last = (emit_item.metric == fpt_pkg::METRIC_LAST);
  end

  assign out_valid = out_valid_q;
  assign out_item  = out_item_q;

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q        <= fpt_pkg::ST_IDLE;
      sample_limit_q <= fpt_pkg::LIMIT_RESET;
      pend_valid_q   <= 1'b0;
      flight_head_q  <= '0;
      flight_count_q <= '0;
      sample_head_q  <= '0;
      sample_count_q <= '0;
      no_cap_q       <= '0;
      rd_pend_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_next;
      rd_pend_q <= (state_q == fpt_pkg::ST_SWEEP) && (j_cnt_q != sample_count_q);

      if (cfg_wr) begin
        sample_limit_q <= pwdata[fpt_pkg::LIMIT_BITS-1:0];
      end

      // Hold or load the output register
      if (emit_req && out_free) begin
        out_valid_q <= 1'b1;
        out_item_q  <= emit_item;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        fpt_pkg::ST_IDLE: begin
          now_q <= in_item.time_now;
          id_q  <= in_item.frame_tag;
          ptr_q <= flight_head_q;
          k_q   <= '0;
          if (in_valid && in_item.mode == fpt_pkg::MODE_TAKEN) begin
            pend_valid_q    <= 1'b1;
            pend_taken_q    <= in_item.time_now;
            pend_has_read_q <= 1'b0;
            pend_read_q     <= '0;
            if (in_item.capture_valid && in_item.capture_time <= in_item.time_now) begin
              pend_cap_valid_q <= 1'b1;
              pend_captured_q  <= in_item.capture_time;
            end else begin
              pend_cap_valid_q <= 1'b0;
              pend_captured_q  <= '0;
              if (no_cap_q != '1) no_cap_q <= no_cap_q + 1'b1;
            end
          end
          if (in_valid && in_item.mode == fpt_pkg::MODE_READ && pend_valid_q) begin
            pend_read_q     <= in_item.time_now;
            pend_has_read_q <= 1'b1;
          end
        end
        // Drop the oldest in-flight entry when full
        fpt_pkg::ST_SENT_ADJ: begin
          if (flight_count_q == FCW'(INFLIGHT_DEPTH)) begin
            flight_head_q  <= f_inc(flight_head_q);
            flight_count_q <= FCW'(INFLIGHT_DEPTH - 1);
          end
        end
        fpt_pkg::ST_SENT_WR: begin
          flight_count_q <= flight_count_q + 1'b1;
          pend_valid_q   <= 1'b0;
        end
        // Match: discard the entry and all older ones
        fpt_pkg::ST_ACK_CMP: begin
          if (fram_rdata.id == id_q) begin
            smp_q.waiting  <= fram_rdata.waiting;
            smp_q.reading  <= fram_rdata.reading;
            smp_q.encoding <= fram_rdata.encoding;
            smp_q.client   <= fpt_pkg::diff_clamp(now_q, fram_rdata.sent);
            flight_head_q  <= f_inc(ptr_q);
            flight_count_q <= flight_count_q - k_q - 1'b1;
          end else begin
            k_q   <= k_q + 1'b1;
            ptr_q <= f_inc(ptr_q);
          end
        end
        fpt_pkg::ST_ACK_SUM1: begin
          smp_q.server <= fpt_pkg::add_sat(smp_q.waiting, smp_q.reading);
        end
        // Finish server time; make room in the ring
        fpt_pkg::ST_ACK_SUM2: begin
          smp_q.server <= fpt_pkg::add_sat(smp_q.server, smp_q.encoding);
          if (sample_count_q >= lim && sample_count_q != '0) begin
            sample_head_q  <= s_inc(sample_head_q);
            sample_count_q <= sample_count_q - 1'b1;
          end
        end
        fpt_pkg::ST_ACK_SUM3: begin
          smp_q.total <= fpt_pkg::add_sat(smp_q.server, smp_q.client);
        end
        fpt_pkg::ST_ACK_WR: begin
          sample_count_q <= sample_count_q + 1'b1;
        end
        fpt_pkg::ST_REP_CNT0: begin
          rank_x_q <= XW'(sample_count_q - 1'b1) * XW'(fpt_pkg::P95_MUL)
                      + XW'(fpt_pkg::P95_BIAS);
          fig_q    <= fpt_pkg::FIG_WAITING;
        end
        fpt_pkg::ST_REP_CNT1: begin
          i95_q <= SCW'(recip_prod >> fpt_pkg::RECIP_SHIFT);
        end
        fpt_pkg::ST_REP_METRIC: begin
          res50_q  <= '0;
          res95_q  <= '0;
          resmax_q <= '0;
          i_cnt_q  <= '0;
          ptr_i_q  <= sample_head_q;
        end
        fpt_pkg::ST_CAND_LD: begin
          cand_q  <= val_j;
          j_cnt_q <= '0;
          ptr_j_q <= sample_head_q;
          less_q  <= '0;
          leq_q   <= '0;
        end
        // Count samples below and not above the candidate
        fpt_pkg::ST_SWEEP: begin
          if (j_cnt_q != sample_count_q) begin
            j_cnt_q <= j_cnt_q + 1'b1;
            ptr_j_q <= s_inc(ptr_j_q);
          end
          if (rd_pend_q) begin
            if (val_j < cand_q)  less_q <= less_q + 1'b1;
            if (val_j <= cand_q) leq_q  <= leq_q + 1'b1;
          end
        end
        // Candidate holds every rank in [less, leq)
        fpt_pkg::ST_DECIDE: begin
          if (less_q <= i50 && i50 < leq_q)     res50_q  <= cand_q;
          if (less_q <= i95_q && i95_q < leq_q) res95_q  <= cand_q;
          if (less_q <= rmax && rmax < leq_q)   resmax_q <= cand_q;
          i_cnt_q <= i_cnt_q + 1'b1;
          ptr_i_q <= s_inc(ptr_i_q);
        end
        fpt_pkg::ST_EMIT95: begin
          if (out_free && fig_q < fpt_pkg::FIG_SERVER) fig_q <= fig_q + 1'b1;
        end
        fpt_pkg::ST_EMITMAX: begin
          if (out_free && fig_q != fpt_pkg::FIG_TOTAL) fig_q <= fig_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/fpt_checker.sv
`default_nettype none

`include "assert_macros.svh"

module fpt_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire fpt_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire fpt_pkg::out_item_t out_item
);

  // A stalled result holds
  `FPT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")

  // Reset leaves the block idle with nothing to deliver
  `FPT_ASSERT_RST(a_reset_idle, rst |=> !out_valid && !in_stall, "not idle after reset")

  // Taken, read and unknown items do not keep the block busy
  `FPT_ASSERT(a_short_items, in_valid && !in_stall && (in_item.mode == fpt_pkg::MODE_TAKEN || in_item.mode == fpt_pkg::MODE_READ || in_item.mode > fpt_pkg::MODE_REPORT) |=> !in_stall, "short item kept block busy")

  // A report keeps the input closed until its final result is loaded
  `FPT_ASSERT(a_report_busy, out_valid && !out_item.last |-> in_stall, "input opened mid report")

endmodule

bind frame_latency_percentile_tracker_core fpt_checker u_fpt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

>>> test/frame_latency_percentile_tracker_core_test.sv
`default_nettype none

module frame_latency_percentile_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_BITS  = fpt_pkg::TIME_BITS;
  localparam int ID_BITS    = fpt_pkg::ID_BITS;
  localparam int LIMIT_BITS = fpt_pkg::LIMIT_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int SETTLE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  fpt_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fpt_pkg::out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  frame_latency_percentile_tracker_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Tracker state mirrored by the predictor
  logic [LIMIT_BITS-1:0] limit_reg;
  bit pend_valid;
  logic [TIME_BITS-1:0] pend_taken;
  bit pend_cap_valid;
  logic [TIME_BITS-1:0] pend_captured;
  bit pend_has_read;
  logic [TIME_BITS-1:0] pend_read;
  logic [31:0] miss_count;
  fpt_pkg::flight_entry_t flights[$];
  fpt_pkg::sample_entry_t samples[$];

  fpt_pkg::out_item_t expected_metrics[$];
  int failures = 0;
  bit quiet = 1'b0;

  // Stimulus helpers
  logic [TIME_BITS-1:0] ticks = '0;
  logic [ID_BITS-1:0] live_ids[$];

  function automatic logic [TIME_BITS-1:0] clamp_diff(logic [TIME_BITS-1:0] later,
                                                      logic [TIME_BITS-1:0] earlier);
    return (later >= earlier) ? later - earlier : '0;
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_sum(logic [TIME_BITS-1:0] a,
                                                   logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  function automatic void reset_tracker();
    limit_reg = fpt_pkg::LIMIT_RESET;
    pend_valid = 0;
    pend_taken = '0;
    pend_cap_valid = 0;
    pend_captured = '0;
    pend_has_read = 0;
    pend_read = '0;
    miss_count = '0;
    flights.delete();
    samples.delete();
  endfunction

  function automatic void push_metric(logic [3:0] m, logic [TIME_BITS-1:0] v);
    fpt_pkg::out_item_t r;
    r.metric = m;
    r.value = v;
    r.last = (m == fpt_pkg::METRIC_LAST);
    expected_metrics.insert(expected_metrics.size(), r);
  endfunction

  // Sorted figure values over the kept samples
  function automatic void report_figures();
    int n, i50, i95;
    logic [TIME_BITS-1:0] vals[$];
    logic [TIME_BITS-1:0] srv, v;
    logic [3:0] base;
    n = samples.size();
    i50 = n / 2;
    i95 = n ? (95 * (n - 1) + 50) / 100 : 0;
    push_metric(fpt_pkg::METRIC_FRAMES, TIME_BITS'(n));
    push_metric(fpt_pkg::METRIC_NO_CAPTURE, {16'd0, miss_count});
    for (int f = 0; f < 6; f++) begin
      vals.delete();
      foreach (samples[k]) begin
        srv = sat_sum(sat_sum(samples[k].waiting, samples[k].reading), samples[k].encoding);
        case (f)
          0: v = samples[k].waiting;
          1: v = samples[k].reading;
          2: v = samples[k].encoding;
          3: v = samples[k].client;
          4: v = srv;
          default: v = sat_sum(srv, samples[k].client);
        endcase
        vals.insert(vals.size(), v);
      end
      vals.sort();
      base = (f < 4) ? fpt_pkg::METRIC_WAIT_P50 + 4'(2 * f) :
             (f == 4) ? fpt_pkg::METRIC_SERVER_P50 : fpt_pkg::METRIC_TOTAL_P50;
      push_metric(base, n ? vals[i50] : '0);
      push_metric(base + 4'd1, n ? vals[i95] : '0);
      if (f >= 4) push_metric(base + 4'd2, n ? vals[n - 1] : '0);
    end
  endfunction

  // Advance the tracker by one accepted item
  function automatic void track_event(fpt_pkg::in_item_t it);
    logic [TIME_BITS-1:0] rd;
    fpt_pkg::flight_entry_t e;
    fpt_pkg::sample_entry_t s;
    int idx, lim;
    case (it.mode)
      fpt_pkg::MODE_TAKEN: begin
        pend_valid = 1;
        pend_taken = it.time_now;
        pend_has_read = 0;
        pend_read = '0;
        if (it.capture_valid && it.capture_time <= it.time_now) begin
          pend_cap_valid = 1;
          pend_captured = it.capture_time;
        end else begin
          pend_cap_valid = 0;
          pend_captured = '0;
          if (miss_count != '1) miss_count++;
        end
      end
      fpt_pkg::MODE_READ: begin
        if (pend_valid) begin
          pend_read = it.time_now;
          pend_has_read = 1;
        end
      end
      fpt_pkg::MODE_SENT: begin
        if (pend_valid) begin
          pend_valid = 0;
          rd = pend_has_read ? pend_read : pend_taken;
          if (flights.size() >= fpt_pkg::INFLIGHT_DEPTH_DEF) flights.delete(0);
          e.id = it.frame_tag;
          e.waiting = pend_cap_valid ? clamp_diff(pend_taken, pend_captured) : '0;
          e.reading = clamp_diff(rd, pend_taken);
          e.encoding = clamp_diff(it.time_now, rd);
          e.sent = it.time_now;
          flights.insert(flights.size(), e);
        end
      end
      fpt_pkg::MODE_ACK: begin
        idx = -1;
        foreach (flights[k]) if (idx < 0 && flights[k].id == it.frame_tag) idx = k;
        if (idx >= 0) begin
          e = flights[idx];
          repeat (idx + 1) flights.delete(0);
          lim = (limit_reg == 0) ? 1 :
                (limit_reg > fpt_pkg::SAMPLE_DEPTH_DEF) ? fpt_pkg::SAMPLE_DEPTH_DEF
                                                        : limit_reg;
          if (samples.size() >= lim && samples.size() > 0) samples.delete(0);
          s = '0;
          s.waiting = e.waiting;
          s.reading = e.reading;
          s.encoding = e.encoding;
          s.client = clamp_diff(it.time_now, e.sent);
          samples.insert(samples.size(), s);
        end
      end
      fpt_pkg::MODE_REPORT: report_figures();
      default: ;
    endcase
  endfunction

  // Send one item, idling before it at random
  task automatic send_event(logic [2:0] mode, logic [TIME_BITS-1:0] now,
                            logic capv, logic [TIME_BITS-1:0] capt,
                            logic [ID_BITS-1:0] id);
    fpt_pkg::in_item_t it;
    it.mode = mode;
    it.time_now = now;
    it.capture_valid = capv;
    it.capture_time = capt;
    it.frame_tag = id;
    if (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    track_event(it);
  endtask

  task automatic write_limit(logic [31:0] v);
    in_valid <= 1'b0;
    wait (expected_metrics.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {fpt_pkg::REG_SAMPLE_LIMIT, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_reg = v[LIMIT_BITS-1:0];
  endtask

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] next_tick();
    if ($urandom_range(19) == 0) ticks = rand_time();
    else ticks = ticks + TIME_BITS'($urandom_range(1, 3000));
    return ticks;
  endfunction

  // One frame: taken, maybe read, maybe sent, maybe an acknowledgment, then noise and maybe a report
  task automatic random_frame();
    logic [TIME_BITS-1:0] now, capt;
    logic [ID_BITS-1:0] id;
    int k, pick;
    now = next_tick();
    pick = $urandom_range(9);
    capt = (pick == 0) ? rand_time() : (pick == 1) ? now + TIME_BITS'(5) :
           clamp_diff(now, TIME_BITS'($urandom_range(0, 2000)));
    send_event(fpt_pkg::MODE_TAKEN, now, $urandom_range(9) != 0, capt, $urandom);
    if ($urandom_range(3) != 0) send_event(fpt_pkg::MODE_READ, next_tick(), 1'($urandom),
                                           rand_time(), $urandom);
    if ($urandom_range(6) != 0) begin
      id = ($urandom_range(2) == 0) ? $urandom_range(0, 7) : $urandom;
      send_event(fpt_pkg::MODE_SENT, next_tick(), 1'($urandom), rand_time(), id);
      live_ids.insert(live_ids.size(), id);
      if (live_ids.size() > fpt_pkg::INFLIGHT_DEPTH_DEF) live_ids.delete(0);
    end
    if ($urandom_range(1) == 0) begin
      if (live_ids.size() > 0 && $urandom_range(6) != 0) begin
        k = $urandom_range(0, live_ids.size() - 1);
        id = live_ids[k];
        repeat (k + 1) live_ids.delete(0);
      end else begin
        id = $urandom;
      end
      send_event(fpt_pkg::MODE_ACK, next_tick(), 1'($urandom), rand_time(), id);
    end
    // Noise: unknown kinds and events with nothing pending
    pick = $urandom_range(19);
    if (pick == 0) send_event(3'($urandom_range(5, 7)), rand_time(), 1'($urandom),
                              rand_time(), $urandom);
    else if (pick == 1) send_event(fpt_pkg::MODE_SENT, next_tick(), 1'b0, '0, $urandom);
    else if (pick == 2) send_event(fpt_pkg::MODE_READ, next_tick(), 1'b0, '0, $urandom);
    if ($urandom_range(99) < 12) send_event(fpt_pkg::MODE_REPORT, ticks, 1'($urandom),
                                            rand_time(), $urandom);
  endtask

  task automatic test_directed();
    // Empty report, then every special case
    send_event(fpt_pkg::MODE_REPORT, '0, 1'b0, '0, '0);
    send_event(fpt_pkg::MODE_READ, 48'd10, 1'b0, '0, '0);
    send_event(fpt_pkg::MODE_SENT, 48'd11, 1'b0, '0, 32'd1);
    send_event(fpt_pkg::MODE_TAKEN, 48'd100, 1'b0, 48'd50, '0);
    send_event(fpt_pkg::MODE_TAKEN, 48'd200, 1'b1, 48'd300, '0);
    send_event(fpt_pkg::MODE_TAKEN, 48'd300, 1'b1, 48'd0, '0);
    send_event(fpt_pkg::MODE_READ, 48'd350, 1'b0, '0, '0);
    send_event(fpt_pkg::MODE_SENT, 48'd400, 1'b0, '0, '1);
    send_event(fpt_pkg::MODE_ACK, 48'd900, 1'b0, '0, 32'h1234_5678);
    send_event(fpt_pkg::MODE_ACK, 48'd900, 1'b0, '0, '1);
    // Backward times and saturating sums
    send_event(fpt_pkg::MODE_TAKEN, TIME_MAX, 1'b1, '0, '0);
    send_event(fpt_pkg::MODE_READ, '0, 1'b0, '0, '0);
    send_event(fpt_pkg::MODE_SENT, TIME_MAX, 1'b0, '0, '0);
    send_event(fpt_pkg::MODE_TAKEN, 48'd5000, 1'b1, 48'd4000, '0);
    send_event(fpt_pkg::MODE_SENT, '0, 1'b1, TIME_MAX, 32'hA5A5_5A5A);
    send_event(fpt_pkg::MODE_ACK, TIME_MAX, 1'b0, '0, '0);
    send_event(fpt_pkg::MODE_ACK, TIME_MAX, 1'b1, TIME_MAX, 32'hA5A5_5A5A);
    send_event(3'd5, TIME_MAX, 1'b1, TIME_MAX, '1);
    send_event(3'd6, '0, 1'b0, '0, '0);
    send_event(3'd7, 48'h5555_5555_5555, 1'b1, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
    send_event(fpt_pkg::MODE_REPORT, TIME_MAX, 1'b1, TIME_MAX, '1);
  endtask

  task automatic test_limit_phase(logic [31:0] lim, int frames);
    write_limit(lim);
    repeat (frames) random_frame();
    send_event(fpt_pkg::MODE_REPORT, ticks, 1'b0, '0, '0);
  endtask

  // Overflow the in-flight table, then acknowledge a dropped frame and the newest frame
  task automatic test_flight_overflow();
    logic [ID_BITS-1:0] id;
    for (int i = 0; i < fpt_pkg::INFLIGHT_DEPTH_DEF + 6; i++) begin
      send_event(fpt_pkg::MODE_TAKEN, next_tick(), 1'b1, ticks, '0);
      id = 32'h0100_0000 + i;
      send_event(fpt_pkg::MODE_SENT, next_tick(), 1'b0, '0, id);
    end
    send_event(fpt_pkg::MODE_ACK, next_tick(), 1'b0, '0, 32'h0100_0000);
    send_event(fpt_pkg::MODE_ACK, next_tick(), 1'b0, '0, id);
    send_event(fpt_pkg::MODE_REPORT, ticks, 1'b0, '0, '0);
    live_ids.delete();
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    fpt_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_metrics.size() == 0) begin
        $error("unexpected result metric=%0d value=%0d", out_item.metric, out_item.value);
        failures++;
      end else begin
        want = expected_metrics[0];
        expected_metrics.delete(0);
        if (out_item.metric !== want.metric) begin
          $error("metric: expected %0d, got %0d", want.metric, out_item.metric);
          failures++;
        end
        if (out_item.value !== want.value) begin
          $error("value (metric %0d): expected %0d, got %0d", want.metric, want.value,
                 out_item.value);
          failures++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          failures++;
        end
      end
    end
  end

  // Stall results at random except during the quiet stretch
  always @(posedge clk) out_stall <= !quiet && ($urandom_range(99) < 21);

  initial begin
    #100ms;
    $display("frame_latency_percentile_tracker_core_test NOT OK");
    $finish;
  end

  initial begin
    reset_tracker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limit_phase(32'd0, 10);
    test_limit_phase(32'd1, 8);
    test_flight_overflow();
    test_limit_phase(32'd6, 10);
    quiet = 1'b1;
    test_limit_phase(32'd256, 10);
    quiet = 1'b0;
    test_limit_phase(32'd511, 8);
    test_limit_phase(32'd3, 7);
    in_valid <= 1'b0;
    wait (expected_metrics.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && expected_metrics.size() == 0) begin
      $display("frame_latency_percentile_tracker_core_test OK");
    end else begin
      $display("frame_latency_percentile_tracker_core_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
